### hdl/mrc_pkg.sv
// mrc_pkg: shared types, constants and the crc-16 byte step for the modbus rtu
// response checker; no dependencies
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;

  localparam logic [POS_W-1:0] POS_ADDR   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FUNC   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_COUNT  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_DATA_L = POS_W'(6);
  localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(7);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  BYTE_COUNT = 8'd4;

  localparam logic [7:0] ADDR_RESET = 8'd1;
  localparam logic [7:0] FUNC_RESET = 8'd4;

  // register indexes on the configuration port
  localparam logic REG_ADDRESS  = 1'b0;
  localparam logic REG_FUNCTION = 1'b1;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_ADDR  = 3'd2,
    ST_FUNC  = 3'd3,
    ST_COUNT = 3'd4,
    ST_CRC   = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [2:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [7:0] expected_address;
    logic [7:0] expected_function;
  } cfg_t;

  // one byte of reflected crc-16, eight shift-xor steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/mrc_cfg_regs.sv
// mrc_cfg_regs: apb-style register file for expected address and function
// depends on mrc_pkg
`timescale 1ns / 1ps

module mrc_cfg_regs
  import mrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_address  <= ADDR_RESET;
      cfg_q.expected_function <= FUNC_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ADDRESS:  cfg_q.expected_address  <= pwdata[7:0];
        REG_FUNCTION: cfg_q.expected_function <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ADDRESS:  prdata = {24'h000000, cfg_q.expected_address};
      REG_FUNCTION: prdata = {24'h000000, cfg_q.expected_function};
      default:      prdata = 32'h0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/mrc_frame.sv
// mrc_frame: per-frame state, byte checks, crc and data packing
// depends on mrc_pkg
`timescale 1ns / 1ps

module mrc_frame
  import mrc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output logic      emit_o,
  output out_word_t result_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [31:0]      data_q, data_d;
  status_e          err_q, err_d;
  logic [7:0]       crc_lo_q, crc_lo_d;

  logic    last_pos;
  logic    frame_done;
  status_e fail;
  status_e status;

  assign last_pos   = (pos_q == POS_LAST);
  assign frame_done = word_i.frame_end || last_pos;

  always_comb begin
    crc_d    = crc_q;
    data_d   = data_q;
    crc_lo_d = crc_lo_q;
    fail     = ST_OK;

    if (pos_q < POS_CRC_LO) begin
      crc_d = crc_byte(crc_q, word_i.rx_byte);
    end

    priority if (pos_q == POS_ADDR) begin
      if (word_i.rx_byte != cfg_i.expected_address) fail = ST_ADDR;
    end else if (pos_q == POS_FUNC) begin
      if (word_i.rx_byte != cfg_i.expected_function) fail = ST_FUNC;
    end else if (pos_q == POS_COUNT) begin
      if (word_i.rx_byte != BYTE_COUNT) fail = ST_COUNT;
    end else if (pos_q <= POS_DATA_L) begin
      data_d = {data_q[23:0], word_i.rx_byte};
    end else if (pos_q == POS_CRC_LO) begin
      crc_lo_d = word_i.rx_byte;
    end else begin
      if ({word_i.rx_byte, crc_lo_q} != crc_q) fail = ST_CRC;
    end

    // keep the first failure only
    err_d = (err_q == ST_OK) ? fail : err_q;

    status = last_pos ? err_d : ST_SHORT;
    pos_d  = pos_q + POS_W'(1);
  end

  assign emit_o              = fire_i && frame_done;
  assign result_o.status     = status;
  assign result_o.value_bits = (status == ST_OK) ? data_d : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= CRC_INIT;
      data_q   <= '0;
      err_q    <= ST_OK;
      crc_lo_q <= '0;
    end else if (fire_i) begin
      if (frame_done) begin
        pos_q    <= '0;
        crc_q    <= CRC_INIT;
        data_q   <= '0;
        err_q    <= ST_OK;
        crc_lo_q <= '0;
      end else begin
        pos_q    <= pos_d;
        crc_q    <= crc_d;
        data_q   <= data_d;
        err_q    <= err_d;
        crc_lo_q <= crc_lo_d;
      end
    end
  end

endmodule

### hdl/modbus_rtu_response_checker_core.sv
// modbus rtu response checker: an accepted byte is held in the input register,
// and the result of its frame is registered in the result register; one byte
// accepted per cycle while the result register is free or drains; the frame logic sits between the two registers
// a held, stalled result stalls the input once the input register is full
// reset (async, active low) clears the frame state and restores the expected
// address to 1 and the expected function to 4
`timescale 1ns / 1ps

module modbus_rtu_response_checker_core
  import mrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input channel
  input  logic        in_valid_i,
  input  in_word_t    in_word_i,
  output logic        in_stall_o,
  // result channel
  output logic        out_valid_o,
  output out_word_t   out_word_o,
  input  logic        out_stall_i,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // input register stage
  logic     in_valid_q;
  in_word_t in_word_q;

  // result register stage
  logic      out_valid_q;
  out_word_t out_word_q;

  logic      adv;      // result register can take a word this cycle
  logic      fire;     // held byte is processed this cycle
  logic      in_take;  // new word accepted from the channel
  logic      emit;
  out_word_t result;
  cfg_t      cfg;

  mrc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mrc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .word_i   (in_word_q),
    .cfg_i    (cfg),
    .emit_o   (emit),
    .result_o (result)
  );

  // the whole pipe moves whenever the result register is free or drains
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  // a failed frame never leaks the data word
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != ST_OK) |-> (out_word_o.value_bits == 32'h0))
    else $error("nonzero value with failing status");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status <= ST_CRC))
    else $error("undefined status code");

  // input side only backs up behind a held, stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");
`endif

endmodule

### tb/mrc_result_checker.sv
// mrc_result_checker: watches the byte and result channels of the modbus rtu
// response checker, predicts each frame result and compares it field by field
// depends on mrc_pkg for the word types, status codes and register indexes
`timescale 1ns / 1ps

module mrc_result_checker
  import mrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_word_t    in_word_i,
  input  logic        in_stall_i,
  input  logic        out_valid_i,
  input  out_word_t   out_word_i,
  input  logic        out_stall_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o
);

  logic [7:0]  want_address;
  logic [7:0]  want_function;
  logic [3:0]  frame_pos;
  logic [15:0] crc_acc;
  logic [31:0] data_acc;
  logic [7:0]  crc_lo;
  status_e     fail_code;
  out_word_t   frame_results[$];
  int          fail_total = 0;
  int          waiting = 0;

  assign errors_o  = fail_total;
  assign pending_o = waiting;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
    return c;
  endfunction

  task automatic note_fail(input status_e code);
    if (fail_code == ST_OK) fail_code = code;
  endtask

  task automatic clear_frame();
    frame_pos = '0;
    crc_acc   = CRC_INIT;
    data_acc  = '0;
    crc_lo    = '0;
    fail_code = ST_OK;
  endtask

  // advance the frame by one byte, queue a result when the frame closes
  task automatic take_byte(input logic [7:0] b, input logic last);
    status_e verdict;
    if (frame_pos < POS_CRC_LO) crc_acc = crc16_update(crc_acc, b);
    if (frame_pos == POS_ADDR) begin
      if (b != want_address) note_fail(ST_ADDR);
    end else if (frame_pos == POS_FUNC) begin
      if (b != want_function) note_fail(ST_FUNC);
    end else if (frame_pos == POS_COUNT) begin
      if (b != BYTE_COUNT) note_fail(ST_COUNT);
    end else if (frame_pos <= POS_DATA_L) begin
      data_acc = {data_acc[23:0], b};
    end else if (frame_pos == POS_CRC_LO) begin
      crc_lo = b;
    end else begin
      if ({b, crc_lo} != crc_acc) note_fail(ST_CRC);
    end
    if (frame_pos != POS_LAST && !last) begin
      frame_pos = frame_pos + 4'd1;
    end else begin
      verdict = (frame_pos != POS_LAST) ? ST_SHORT : fail_code;
      frame_results.push_back({(verdict == ST_OK) ? data_acc : 32'h0, verdict});
      clear_frame();
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (frame_results.size() == 0) begin
      $error("result with none pending: value_bits %h status %0d", got.value_bits, got.status);
      fail_total++;
    end else begin
      want = frame_results.pop_front();
      if (got.value_bits !== want.value_bits) begin
        $error("value_bits: expected %h, actual %h", want.value_bits, got.value_bits);
        fail_total++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fail_total++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_address  = ADDR_RESET;
      want_function = FUNC_RESET;
      clear_frame();
      frame_results.delete();
    end else begin
      // a result leaving now belongs to an earlier byte, so retire it first
      if (out_valid_i && !out_stall_i) check_result(out_word_i);
      if (in_valid_i && !in_stall_i) take_byte(in_word_i.rx_byte, in_word_i.frame_end);
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_ADDRESS, 2'b00}) want_address = pwdata[7:0];
        else if (paddr == {REG_FUNCTION, 2'b00}) want_function = pwdata[7:0];
      end
    end
    waiting = frame_results.size();
  end

endmodule

### tb/testbench.sv
// testbench: drives byte frames and register writes into the modbus rtu
// response checker core and gives the verdict
// depends on mrc_pkg, modbus_rtu_response_checker_core and mrc_result_checker
`timescale 1ns / 1ps

module testbench;
  import mrc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the pipe
  localparam int SETTLE_CYCLES = 8;     // a few times the two-register pipe depth
  localparam int PHASE_ITEMS   = 86;

  // register byte addresses, index times four
  localparam logic [2:0] ADDR_REG_ADDRESS  = {REG_ADDRESS, 2'b00};
  localparam logic [2:0] ADDR_REG_FUNCTION = {REG_FUNCTION, 2'b00};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_word_t    in_word = '0;
  logic        in_stall;
  logic        out_valid;
  out_word_t   out_word;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;

  // sender bookkeeping
  int          items_sent = 0;
  int          burst_left = 1;
  bit          offering = 1'b0;
  int          hold_req = 0;
  logic [7:0]  cur_address = ADDR_RESET;
  logic [7:0]  cur_function = FUNC_RESET;

  modbus_rtu_response_checker_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_word_i   (in_word),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_word_o  (out_word),
    .out_stall_i (out_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  mrc_result_checker i_results (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_word_i   (in_word),
    .in_stall_i  (in_stall),
    .out_valid_i (out_valid),
    .out_word_i  (out_word),
    .out_stall_i (out_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case a word never arrives
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: stall pattern changes mode after a random span; on request
  // it holds off for a long stretch so the block backs up into its input
  initial begin
    int mode;
    int span;
    int hold_served;
    mode = 0;
    span = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
        end
        span--;
        case (mode)
          0: out_stall <= 1'b0;                          // free flowing
          1: out_stall <= ($urandom_range(0, 3) == 0);   // light stalls
          2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy stalls
          default: out_stall <= ~out_stall;               // toggling
        endcase
      end
    end
  end

  // offer one byte and hold it until taken; bursts end with a random gap,
  // some bursts run straight into the next one with no gap
  task automatic push_byte(input logic [7:0] b, input logic fe);
    in_valid <= 1'b1;
    in_word  <= {b, fe};
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 4) != 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait until every pending word has come out
  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do begin
      while (pending != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending != 0);
  endtask

  // setup then access cycle; the trailing cycle keeps back-to-back writes apart
  task automatic reg_write(input logic [2:0] addr, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change with the block idle
  task automatic set_regs(input logic [7:0] address, input logic [7:0] func);
    drain();
    reg_write(ADDR_REG_ADDRESS, address);
    reg_write(ADDR_REG_FUNCTION, func);
    cur_address  = address;
    cur_function = func;
  endtask

  // build a nine-byte response with a matching crc (optionally corrupted)
  // and send its first len bytes; frame_end marks the last byte of a short
  // frame, and the ninth byte only when mark_ninth is set
  task automatic send_frame(input logic [7:0] address, input logic [7:0] func,
                            input logic [7:0] count, input logic [31:0] data,
                            input bit crc_bad, input int len, input bit mark_ninth);
    logic [7:0]  frame [0:8];
    logic [15:0] crc;
    frame[0] = address;
    frame[1] = func;
    frame[2] = count;
    frame[3] = data[31:24];
    frame[4] = data[23:16];
    frame[5] = data[15:8];
    frame[6] = data[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 7; i++) crc = crc_byte(crc, frame[i]);
    frame[7] = crc[7:0];
    frame[8] = crc[15:8];
    if (crc_bad) frame[7 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    for (int i = 0; i < len; i++) begin
      push_byte(frame[i], (i == len - 1) && (len < FRAME_BYTES || mark_ninth));
    end
  endtask

  // mostly well-formed frames against the current registers, with the
  // occasional bad header byte, bad crc or early frame end
  task automatic random_frame();
    logic [31:0] data;
    int len;
    data = $urandom();
    case ($urandom_range(0, 7))
      0: data = 32'h0000_0000;
      1: data = 32'hFFFF_FFFF;
      default: ;
    endcase
    len = ($urandom_range(0, 99) < 85) ? FRAME_BYTES : $urandom_range(1, FRAME_BYTES - 1);
    send_frame(($urandom_range(0, 9) == 0) ? 8'($urandom()) : cur_address,
               ($urandom_range(0, 9) == 0) ? 8'($urandom()) : cur_function,
               ($urandom_range(0, 9) == 0) ? 8'($urandom()) : BYTE_COUNT,
               data, ($urandom_range(0, 7) == 0), len, $urandom_range(0, 1));
  endtask

  // raw bytes with scattered frame ends, breaks framing on purpose
  task automatic noise_burst();
    int len;
    len = $urandom_range(1, 12);
    repeat (len) push_byte(8'($urandom()), ($urandom_range(0, 5) == 0));
  endtask

  task automatic run_phase(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 9) == 0) noise_burst();
      else random_frame();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: good frame of all-ones data ended by frame_end on the ninth
    // byte, then a frame failing address, function, count and crc at once
    // with no frame_end, then a one-byte and a five-byte short frame
    send_frame(ADDR_RESET, FUNC_RESET, BYTE_COUNT, 32'hFFFF_FFFF, 1'b0, FRAME_BYTES, 1'b1);
    send_frame(8'h00, 8'hFF, 8'h00, 32'h0000_0000, 1'b1, FRAME_BYTES, 1'b0);
    send_frame(ADDR_RESET, FUNC_RESET, BYTE_COUNT, 32'h0, 1'b0, 1, 1'b0);
    send_frame(ADDR_RESET, FUNC_RESET, BYTE_COUNT, 32'h1234_5678, 1'b0, 5, 1'b0);

    // random phases under several register settings, extremes first
    run_phase(PHASE_ITEMS);
    set_regs(8'h00, 8'h00);
    hold_req++;               // long receiver hold-off while bytes keep coming
    run_phase(PHASE_ITEMS);
    set_regs(8'hFF, 8'hFF);
    run_phase(PHASE_ITEMS);
    set_regs(8'($urandom()), 8'($urandom()));
    run_phase(PHASE_ITEMS);
    set_regs(8'($urandom()), 8'($urandom()));
    run_phase(PHASE_ITEMS);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
